// ----- rtl/core/rca_pkg.sv -----
// Shared types, constants and codes for the ratiometric converter averager.
package rca_pkg;

   localparam int NUM_SLOTS   = 8;
   localparam int SAMPLE_BITS = 12;

   localparam int SLOT_W  = 3;
   localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SUM_W   = 20;
   localparam int SUMX_W  = SUM_W + 1;
   localparam int CNT_W   = 8;
   localparam int VREF_W  = 16;
   localparam int MV_W    = 29;
   localparam int PROD_W  = SUM_W + VREF_W + 1;
   localparam int STEP_W  = $clog2(PROD_W + 1);
   localparam int N_RESULTS = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;
   localparam int KW      = (N_RESULTS > 1) ? $clog2(N_RESULTS) : 1;
   localparam int REF_SLOT = 3;
   localparam int BATT_SLOT = 0;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam logic [MV_W-1:0]  MV_MAX  = '1;

   localparam logic [CNT_W-1:0]  CNT_RESET  = CNT_W'(16);
   localparam logic [VREF_W-1:0] VREF_RESET = VREF_W'(1200);

   // request codes
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   // register indexes
   localparam logic CSR_SAMPLE_COUNT = 1'b0;
   localparam logic CSR_REF_MV       = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_REF_FETCH,
      ST_REF_START,
      ST_REF_WAIT,
      ST_SLOT_FETCH,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_MUL,
      ST_QUO_START,
      ST_QUO_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [PROD_W-1:0] num;
      logic [SUM_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [SUM_W-1:0] wr_data;
      logic             clear_all;
   } acc_ctrl_type;

endpackage

// ----- rtl/core/ratiometric_adc_averager.sv -----
// Top level: slot accumulators, sequencer and result register of the averager.
//
//  channel  direction  handshake             word
//  req_     in         req_valid/req_stall   req_type, req_slot, req_sample
//  rsp_     out        rsp_valid/rsp_stall   rsp_slot_res, rsp_millivolts,
//                                            rsp_div_error, rsp_last
//  csr_     in         csr_valid/csr_ready   csr_index, csr_data
//
// A sample word is a registered read of its accumulator, then a
// saturating add and write back.
// A finish also waits on rsp_stall: one shared bit-serial divider gives
// the reference average (20 steps), then per slot the average
// (20 steps), a multiply step and the ratio (37 steps); the ratio is
// skipped when the reference average is zero.
// req_stall is high whenever the sequencer is not idle; rsp_stall holds
// the current result word and the walk waits on it.
// Reset (synchronous) clears the accumulators through their valid bits and
// loads sample_count = 16, reference_millivolts = 1200.
module ratiometric_adc_averager
   import rca_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_type,
   input  logic [SLOT_W-1:0]      req_slot,
   input  logic [SAMPLE_BITS-1:0] req_sample,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SLOT_W-1:0]      rsp_slot_res,
   output logic [MV_W-1:0]        rsp_millivolts,
   output logic                   rsp_div_error,
   output logic                   rsp_last,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [VREF_W-1:0]      csr_data
);

   state_type state_ff, state_in;

   // configuration
   logic [CNT_W-1:0]  cnt_cfg_ff;
   logic [VREF_W-1:0] vref_ff;

   // sample word held for the write-back cycle
   logic [IDX_W-1:0]       smp_slot_ff;
   logic                   smp_ok_ff;
   logic [SAMPLE_BITS-1:0] smp_ff;

   // finish walk
   logic [KW-1:0]     k_ff;
   logic [SUM_W-1:0]  ref_avg_ff;
   logic [SUM_W-1:0]  avg_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [MV_W-1:0]   mv_ff;
   logic              err_ff;

   div_req_type       div_req;
   logic              div_done;
   logic [PROD_W-1:0] div_quo;
   acc_ctrl_type      acc_ctrl;
   logic [SUM_W-1:0]  acc_rd;

   logic [SUMX_W-1:0]       sum_wide;
   logic [SUM_W-1:0]        sum_sat;
   logic [CNT_W-1:0]        cnt_eff;
   logic [SUM_W+VREF_W-1:0] prod_raw;
   logic [PROD_W-1:0]       prod_in;
   logic                    k_last;
   logic                    k_is_ref;
   logic                    k_is_batt;

   rca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   rca_acc_mem u_acc (
      .clock    (clock),
      .reset    (reset),
      .acc_ctrl (acc_ctrl),
      .rd_data  (acc_rd)
   );

   assign k_last    = k_ff == KW'(N_RESULTS - 1);
   assign k_is_ref  = k_ff == KW'(REF_SLOT);
   assign k_is_batt = k_ff == KW'(BATT_SLOT);
   assign cnt_eff   = (cnt_cfg_ff == '0) ? CNT_W'(1) : cnt_cfg_ff;

   // saturating accumulate
   assign sum_wide = {1'b0, acc_rd} + SUMX_W'(smp_ff);
   assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

   // supply: 2^SAMPLE_BITS * vref; battery: doubled by the divider
   assign prod_raw = avg_ff * vref_ff;
   always_comb begin
      if (k_is_ref) begin
         prod_in = PROD_W'(vref_ff) << SAMPLE_BITS;
      end else if (k_is_batt) begin
         prod_in = {prod_raw, 1'b0};
      end else begin
         prod_in = PROD_W'(prod_raw);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_type == REQ_FINISH) ? ST_REF_FETCH : ST_ADD;
            end
         end
         ST_ADD:        state_in = ST_IDLE;
         ST_REF_FETCH:  state_in = ST_REF_START;
         ST_REF_START:  state_in = ST_REF_WAIT;
         ST_REF_WAIT: begin
            if (div_done) begin
               state_in = ST_SLOT_FETCH;
            end
         end
         ST_SLOT_FETCH: state_in = ST_AVG_START;
         ST_AVG_START:  state_in = ST_AVG_WAIT;
         ST_AVG_WAIT: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:        state_in = (ref_avg_ff == '0) ? ST_EMIT : ST_QUO_START;
         ST_QUO_START:  state_in = ST_QUO_WAIT;
         ST_QUO_WAIT: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               state_in = k_last ? ST_IDLE : ST_SLOT_FETCH;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall          = 1'b1;
      rsp_valid          = 1'b0;
      div_req.start      = 1'b0;
      div_req.steps      = STEP_W'(SUM_W);
      div_req.num        = {acc_rd, (PROD_W - SUM_W)'(0)};
      div_req.den        = SUM_W'(cnt_eff);
      acc_ctrl.rd_addr   = IDX_W'(k_ff);
      acc_ctrl.wr_en     = 1'b0;
      acc_ctrl.wr_addr   = smp_slot_ff;
      acc_ctrl.wr_data   = sum_sat;
      acc_ctrl.clear_all = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall        = 1'b0;
            acc_ctrl.rd_addr = IDX_W'(req_slot);
         end
         ST_ADD: begin
            acc_ctrl.wr_en = smp_ok_ff;
         end
         ST_REF_FETCH: begin
            acc_ctrl.rd_addr = IDX_W'(REF_SLOT);
         end
         ST_REF_START, ST_AVG_START: begin
            div_req.start = 1'b1;
         end
         ST_QUO_START: begin
            div_req.start = 1'b1;
            div_req.steps = STEP_W'(PROD_W);
            div_req.num   = prod_ff;
            div_req.den   = ref_avg_ff;
         end
         ST_EMIT: begin
            rsp_valid          = 1'b1;
            acc_ctrl.clear_all = !rsp_stall && k_last;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_cfg_ff <= CNT_RESET;
         vref_ff    <= VREF_RESET;
         k_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SAMPLE_COUNT: cnt_cfg_ff <= csr_data[CNT_W-1:0];
               CSR_REF_MV:       vref_ff    <= csr_data;
               default:          vref_ff    <= vref_ff;
            endcase
         end
         if (state_ff == ST_REF_FETCH) begin
            k_ff <= '0;
         end else if (state_ff == ST_EMIT && !rsp_stall && !k_last) begin
            k_ff <= k_ff + KW'(1);
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         smp_slot_ff <= IDX_W'(req_slot);
         smp_ok_ff   <= int'(req_slot) < NUM_SLOTS;
         smp_ff      <= req_sample;
      end
      if (state_ff == ST_REF_WAIT && div_done) begin
         ref_avg_ff <= div_quo[SUM_W-1:0];
      end
      if (state_ff == ST_AVG_WAIT && div_done) begin
         avg_ff <= div_quo[SUM_W-1:0];
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= prod_in;
         mv_ff   <= '0;
         err_ff  <= ref_avg_ff == '0;
      end
      if (state_ff == ST_QUO_WAIT && div_done) begin
         mv_ff <= (div_quo > PROD_W'(MV_MAX)) ? MV_MAX : div_quo[MV_W-1:0];
      end
   end

   assign csr_ready      = 1'b1;
   assign rsp_slot_res   = SLOT_W'(k_ff);
   assign rsp_millivolts = mv_ff;
   assign rsp_div_error  = err_ff;
   assign rsp_last       = k_last;

`ifndef NO_ASSERTIONS
   a_busy_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result word is pending");
   a_err_zero_mv: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_error) |-> rsp_millivolts == '0)
      else $error("error result carries a voltage");
   a_gap_after_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result word repeated without recompute");
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !req_stall)
      else $error("sequencer not idle after final result");
`endif

endmodule

// ----- rtl/core/rca_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module rca_div
   import rca_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_req_type       div_req,
   output logic              div_done,
   output logic [PROD_W-1:0] div_quo
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  den_ff, den_in;
   logic [PROD_W-1:0] q_ff, q_in;

   logic [SUMX_W-1:0] shifted;
   logic [SUMX_W-1:0] diff;
   logic              ge;

   assign shifted = {rem_ff, q_ff[PROD_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.steps;
         rem_in  = '0;
         den_in  = div_req.den;
         q_in    = div_req.num;
      end else if (busy_ff) begin
         rem_in = ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
         q_in   = {q_ff[PROD_W-2:0], ge};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign div_done = done_ff;
   assign div_quo  = q_ff;

`ifndef NO_ASSERTIONS
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff)
      else $error("divider finished without done");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");
`endif

endmodule

// ----- rtl/core/rca_acc_mem.sv -----
// Slot accumulator store with per-entry valid bits and registered read.
module rca_acc_mem
   import rca_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  acc_ctrl_type     acc_ctrl,
   output logic [SUM_W-1:0] rd_data
);

   logic [SUM_W-1:0]     mem_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [SUM_W-1:0]     rd_data_ff;

   always_ff @(posedge clock) begin
      if (acc_ctrl.wr_en) begin
         mem_ff[acc_ctrl.wr_addr] <= acc_ctrl.wr_data;
      end
      // an entry not written since the last clear reads as zero
      rd_data_ff <= valid_ff[acc_ctrl.rd_addr] ? mem_ff[acc_ctrl.rd_addr] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (acc_ctrl.clear_all) begin
         valid_ff <= '0;
      end else if (acc_ctrl.wr_en) begin
         valid_ff[acc_ctrl.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- bench/ratiometric_adc_averager_tb.sv -----
// Self-checking testbench for the ratiometric converter averager.
`timescale 1ns / 100ps

module ratiometric_adc_averager_tb;
   import rca_pkg::*;

   localparam int RANDOM_ITEMS  = 40;
   localparam int SETTLE_CYCLES = 8;       // margin for a sample word's read and write-back
   localparam int END_PAUSE     = 600;     // one full finish walk, with margin
   localparam int CYCLE_LIMIT   = 2000000;

   // one expected result word
   typedef struct {
      logic [SLOT_W-1:0] slot;
      logic [MV_W-1:0]   mv;
      logic              err;
      logic              last;
   } volt_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid  = 1'b0;
   logic                   req_stall;
   logic                   req_type   = REQ_SAMPLE;
   logic [SLOT_W-1:0]      req_slot   = '0;
   logic [SAMPLE_BITS-1:0] req_sample = '0;

   logic                   rsp_valid;
   logic                   rsp_stall  = 1'b1;
   logic [SLOT_W-1:0]      rsp_slot_res;
   logic [MV_W-1:0]        rsp_millivolts;
   logic                   rsp_div_error;
   logic                   rsp_last;

   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic                   csr_index  = CSR_SAMPLE_COUNT;
   logic [VREF_W-1:0]      csr_data   = '0;

   // own copy of the block's state and registers
   logic [SUM_W-1:0]  slot_acc [NUM_SLOTS];
   logic [CNT_W-1:0]  cfg_count = CNT_RESET;
   logic [VREF_W-1:0] cfg_vref  = VREF_RESET;

   volt_word_type pending_volts [$];

   // pacing of both sides
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int rsp_gap = 0;
   int rsp_hold_cycles = 0;

   int cycle_count = 0;
   int words_sent = 0;
   int finishes_sent = 0;
   int volts_checked = 0;
   int csr_writes = 0;
   int fails = 0;

   ratiometric_adc_averager u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_slot       (req_slot),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot_res   (rsp_slot_res),
      .rsp_millivolts (rsp_millivolts),
      .rsp_div_error  (rsp_div_error),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ratiometric_adc_averager regression: fail");
         $finish;
      end
   end

   // idle cycles before a word; at least a quarter of draws are zero so bursts happen too
   function automatic int draw_gap(input bit calm);
      if (calm || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, 14);
   endfunction

   // sample values lean on the rails
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return SAMPLE_BITS'($urandom_range(0, 4095));
      endcase
   endfunction

   // count register data; upper byte is junk the block must drop
   function automatic logic [VREF_W-1:0] pick_count_data();
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0: return {junk, 8'd0};
         1: return {junk, 8'd255};
         2: return {junk, 8'($urandom_range(1, 255))};
         default: return {junk, 8'($urandom_range(1, 4))};
      endcase
   endfunction

   function automatic logic [VREF_W-1:0] pick_vref();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return VREF_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Fold one accepted word into the accumulators; a finish queues the eight
   // voltages it must produce and clears the sums.
   task automatic fold_word(input logic kind, input logic [SLOT_W-1:0] slot,
                            input logic [SAMPLE_BITS-1:0] smp);
      logic [SUMX_W-1:0] sum_x;
      logic [63:0] cnt;
      logic [63:0] ref_avg;
      logic [63:0] avg;
      logic [63:0] mv;
      volt_word_type w;
      if (kind == REQ_SAMPLE) begin
         sum_x = {1'b0, slot_acc[slot]} + SUMX_W'(smp);
         slot_acc[slot] = (sum_x > SUM_MAX) ? SUM_MAX : sum_x[SUM_W-1:0];
      end else begin
         cnt = (cfg_count == 0) ? 64'd1 : 64'(cfg_count);
         ref_avg = 64'(slot_acc[REF_SLOT]) / cnt;
         for (int k = 0; k < N_RESULTS; k++) begin
            avg = 64'(slot_acc[k]) / cnt;
            if (ref_avg == 0)
               mv = 0;
            else if (k == REF_SLOT)
               mv = (64'd1 << SAMPLE_BITS) * 64'(cfg_vref) / ref_avg;
            else if (k == BATT_SLOT)
               mv = avg * 64'(cfg_vref) * 64'd2 / ref_avg;   // divide-by-two divider
            else
               mv = avg * 64'(cfg_vref) / ref_avg;
            w.slot = SLOT_W'(k);
            w.mv   = (mv > 64'(MV_MAX)) ? MV_MAX : mv[MV_W-1:0];
            w.err  = (ref_avg == 0);
            w.last = (k == N_RESULTS - 1);
            pending_volts.push_back(w);
         end
         for (int k = 0; k < NUM_SLOTS; k++)
            slot_acc[k] = '0;
      end
   endtask

   // Offer one word after a random gap; returns at the edge that took it.
   // valid is left high so the next word can follow back to back.
   task automatic push_word(input logic kind, input logic [SLOT_W-1:0] slot,
                            input logic [SAMPLE_BITS-1:0] smp);
      int gap;
      gap = draw_gap(req_calm);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_type   <= kind;
      req_slot   <= slot;
      req_sample <= smp;
      do @(posedge clock); while (!(req_valid && !req_stall));
      fold_word(kind, slot, smp);
      words_sent++;
      if (kind == REQ_FINISH)
         finishes_sent++;
   endtask

   // slot and sample carry junk on a finish
   task automatic push_finish();
      push_word(REQ_FINISH, SLOT_W'($urandom_range(0, 7)), SAMPLE_BITS'($urandom_range(0, 4095)));
   endtask

   // Sender pauses until every queued voltage is back and the block is idle.
   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_volts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [VREF_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      if (idx == CSR_SAMPLE_COUNT)
         cfg_count = data[CNT_W-1:0];
      else
         cfg_vref = data;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver: stall is high while a drawn gap is pending and counts down only
   // while a word is on offer; a hold-off counts plain cycles.
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_cycles--;
      end else if (rsp_gap > 0) begin
         rsp_stall <= 1'b1;
         if (rsp_valid)
            rsp_gap--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result checker: each accepted word against the oldest expectation.
   always @(posedge clock) begin : check_volts
      volt_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_gap = draw_gap(rsp_calm);
         if (pending_volts.size() == 0) begin
            $error("result word slot %0d with nothing expected", rsp_slot_res);
            fails++;
         end else begin
            want = pending_volts.pop_front();
            volts_checked++;
            if (rsp_slot_res !== want.slot) begin
               $error("slot_res: expected %0d, got %0d", want.slot, rsp_slot_res);
               fails++;
            end
            if (rsp_millivolts !== want.mv) begin
               $error("millivolts: expected %0d, got %0d", want.mv, rsp_millivolts);
               fails++;
            end
            if (rsp_div_error !== want.err) begin
               $error("div_error: expected %0b, got %0b", want.err, rsp_div_error);
               fails++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               fails++;
            end
         end
      end
   end

   // Finish straight out of reset: all sums zero so every word flags the
   // divide error; then a small batch under the reset count and reference.
   task automatic test_reset_defaults();
      push_finish();
      push_word(REQ_SAMPLE, 3'd3, 12'd4095);
      push_word(REQ_SAMPLE, 3'd2, 12'd1000);
      push_finish();
      wait_quiet();
   endtask

   // Count of one and full-scale reference: battery slot at its largest
   // unsaturated value, slot 1 past the voltage ceiling, reference of one.
   task automatic test_extremes();
      write_reg(CSR_SAMPLE_COUNT, 16'h0001);
      write_reg(CSR_REF_MV, 16'hFFFF);
      push_word(REQ_SAMPLE, 3'd0, 12'd4095);
      repeat (3) push_word(REQ_SAMPLE, 3'd1, 12'd4095);
      push_word(REQ_SAMPLE, 3'd2, 12'd0);
      push_word(REQ_SAMPLE, 3'd3, 12'd1);
      push_word(REQ_SAMPLE, 3'd4, 12'd4095);
      push_word(REQ_SAMPLE, 3'd5, 12'd2048);
      push_word(REQ_SAMPLE, 3'd6, 12'd1);
      push_word(REQ_SAMPLE, 3'd7, 12'd4095);
      push_finish();
      wait_quiet();
   endtask

   // Count byte of zero must act as one; upper data bits are don't-care.
   task automatic test_zero_count();
      write_reg(CSR_SAMPLE_COUNT, 16'hFF00);
      push_word(REQ_SAMPLE, 3'd3, 12'd7);
      push_word(REQ_SAMPLE, 3'd6, 12'd100);
      push_finish();
      wait_quiet();
   endtask

   // Count of 255 truncates; zero reference voltage gives zeros without the
   // flag; a reference average that truncates to zero raises the flag.
   task automatic test_zero_reference();
      write_reg(CSR_SAMPLE_COUNT, 16'h00FF);
      write_reg(CSR_REF_MV, 16'h0000);
      push_word(REQ_SAMPLE, 3'd3, 12'd4095);
      push_word(REQ_SAMPLE, 3'd0, 12'd4094);
      push_finish();
      wait_quiet();
      write_reg(CSR_REF_MV, 16'd1200);
      push_word(REQ_SAMPLE, 3'd3, 12'd254);
      push_word(REQ_SAMPLE, 3'd0, 12'd4095);
      push_finish();
      wait_quiet();
   endtask

   // Drive the battery accumulator past 2^20-1 so it must clip.
   task automatic test_sum_saturation();
      req_calm = 1'b1;
      write_reg(CSR_SAMPLE_COUNT, 16'h0001);
      write_reg(CSR_REF_MV, 16'd3300);
      push_word(REQ_SAMPLE, 3'd3, 12'd4095);
      repeat (258) push_word(REQ_SAMPLE, 3'd0, 12'd4095);
      push_word(REQ_SAMPLE, 3'd7, pick_sample());
      push_finish();
      wait_quiet();
      req_calm = 1'b0;
   endtask

   // Receiver holds off long enough that a finish backs up and the block
   // stalls the next batch; afterwards the sender waits out a full drain
   // between two batches.
   task automatic test_backpressure();
      write_reg(CSR_SAMPLE_COUNT, 16'h0002);
      write_reg(CSR_REF_MV, pick_vref());
      req_calm = 1'b1;
      rsp_hold_cycles = 400;
      repeat (2) begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            push_word(REQ_SAMPLE, SLOT_W'(k), pick_sample());
            push_word(REQ_SAMPLE, SLOT_W'(k), pick_sample());
         end
         push_finish();
      end
      req_calm = 1'b0;
      wait_quiet();
      for (int k = 0; k < NUM_SLOTS; k++)
         push_word(REQ_SAMPLE, SLOT_W'(k), pick_sample());
      push_finish();
      wait_quiet();
      push_word(REQ_SAMPLE, 3'd3, pick_sample());
      push_word(REQ_SAMPLE, 3'd3, pick_sample());
      push_finish();
      wait_quiet();
   endtask

   // Mostly complete batches (count samples per slot, or 1 to 5 above a count of 5,
   // shuffled) with random content; some rounds are ragged or miss the reference slot.
   task automatic test_random_rounds();
      int start_words;
      int eff;
      int per_slot;
      int idx;
      int split;
      logic [SLOT_W-1:0] order [$];
      logic [SLOT_W-1:0] s;
      start_words = words_sent;
      while (words_sent - start_words < RANDOM_ITEMS) begin
         req_calm = ($urandom_range(0, 5) == 0);
         rsp_calm = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 2) == 0) begin
            wait_quiet();
            write_reg(CSR_SAMPLE_COUNT, pick_count_data());
         end
         if ($urandom_range(0, 2) == 0) begin
            wait_quiet();
            write_reg(CSR_REF_MV, pick_vref());
         end
         order.delete();
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(0, 12))
               order.push_back(SLOT_W'($urandom_range(0, 7)));
         end else begin
            eff = (cfg_count == 0) ? 1 : int'(cfg_count);
            per_slot = (eff > 5) ? $urandom_range(1, 5) : eff;
            for (int k = 0; k < NUM_SLOTS; k++)
               repeat (per_slot) order.push_back(SLOT_W'(k));
         end
         split = ($urandom_range(0, 5) == 0) ? order.size() / 2 : -1;
         while (order.size() != 0) begin
            // reference change part-way through a batch, sums kept
            if (order.size() == split) begin
               wait_quiet();
               write_reg(CSR_REF_MV, pick_vref());
            end
            idx = $urandom_range(0, order.size() - 1);
            s = order[idx];
            order.delete(idx);
            push_word(REQ_SAMPLE, s, pick_sample());
         end
         push_finish();
      end
      req_calm = 1'b0;
      rsp_calm = 1'b0;
   endtask

   initial begin
      for (int k = 0; k < NUM_SLOTS; k++)
         slot_acc[k] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_extremes();
      test_zero_count();
      test_zero_reference();
      test_backpressure();
      test_sum_saturation();
      test_random_rounds();

      wait_quiet();
      repeat (END_PAUSE) @(posedge clock);   // catch any stray result words
      if (pending_volts.size() != 0)
         fails++;

      $display("run: %0d words in, %0d finishes, %0d voltages checked, %0d register writes",
               words_sent, finishes_sent, volts_checked, csr_writes);
      $display("     %0d cycles, %0d mismatches", cycle_count, fails);
      if (fails == 0)
         $display("ratiometric_adc_averager regression: pass");
      else
         $display("ratiometric_adc_averager regression: fail");
      $finish;
   end

endmodule
